[rtl/gvm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_pkg
// Shared types and constants of the gamepad to velocity mapper: payload
// structs, configuration bundle, register indexes and reset values.
// ----------------------------------------------------------------------------
package gvm_pkg;

   // field widths
   localparam int AXIS_WIDTH        = 16;
   localparam int SPEED_WIDTH       = 15;
   localparam int VEL_WIDTH         = 16;
   localparam int BUTTON_WIDTH      = 6;
   localparam int HELD_WIDTH        = 4;
   localparam int IDLE_LIMIT_WIDTH  = 16;
   localparam int CSR_ADDR_WIDTH    = 5;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int CSR_INDEX_WIDTH   = 3;

   // item kinds
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   // axis thresholds, +0.5 and -0.5 in Q1.15
   localparam logic signed [AXIS_WIDTH-1:0] AXIS_HALF_POS = 16'sd16384;
   localparam logic signed [AXIS_WIDTH-1:0] AXIS_HALF_NEG = -16'sd16384;

   // rounding constant for the Q4.12 x Q1.15 product, half an lsb after >> 15
   localparam logic signed [31:0] SCALE_ROUND = 32'sd16384;

   // button positions within button_bits
   localparam int BTN_LIN_DOWN   = 0;
   localparam int BTN_TURN_UP    = 1;
   localparam int BTN_TURN_DOWN  = 2;
   localparam int BTN_LIN_UP     = 3;
   localparam int BTN_TURN_LEFT  = 4;
   localparam int BTN_TURN_RIGHT = 5;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DEAD_BAND    = 3'd0,
      REG_SPEED_STEP   = 3'd1,
      REG_SPEED_LIMIT  = 3'd2,
      REG_IDLE_LIMIT   = 3'd3,
      REG_START_LINEAR = 3'd4,
      REG_START_TURN   = 3'd5
   } reg_index_type;

   // register reset values
   localparam logic [SPEED_WIDTH-1:0]      RST_DEAD_BAND    = 15'd3277;
   localparam logic [SPEED_WIDTH-1:0]      RST_SPEED_STEP   = 15'd410;
   localparam logic [SPEED_WIDTH-1:0]      RST_SPEED_LIMIT  = 15'd20480;
   localparam logic [IDLE_LIMIT_WIDTH-1:0] RST_IDLE_LIMIT   = 16'd5;
   localparam logic [SPEED_WIDTH-1:0]      RST_START_LINEAR = 15'd1229;
   localparam logic [SPEED_WIDTH-1:0]      RST_START_TURN   = 15'd2048;

   // stop cause codes
   typedef enum logic [1:0] {
      CAUSE_NORMAL = 2'd0,
      CAUSE_ESTOP  = 2'd1,
      CAUSE_IDLE   = 2'd2
   } stop_cause_type;

   // configuration bundle
   typedef struct packed {
      logic [SPEED_WIDTH-1:0]      dead_band;
      logic [SPEED_WIDTH-1:0]      speed_step;
      logic [SPEED_WIDTH-1:0]      speed_limit;
      logic [IDLE_LIMIT_WIDTH-1:0] idle_limit_ticks;
   } cfg_type;

   // speed setting loads from the start registers
   typedef struct packed {
      logic                   load_linear;
      logic                   load_turn;
      logic [SPEED_WIDTH-1:0] value;
   } speed_load_type;

   // one request
   typedef struct packed {
      logic                          mode;
      logic signed [AXIS_WIDTH-1:0]  stick_x;
      logic signed [AXIS_WIDTH-1:0]  stick_y;
      logic signed [AXIS_WIDTH-1:0]  pad_vertical;
      logic signed [AXIS_WIDTH-1:0]  pad_horizontal;
      logic signed [AXIS_WIDTH-1:0]  trigger_left;
      logic signed [AXIS_WIDTH-1:0]  trigger_right;
      logic [BUTTON_WIDTH-1:0]       button_bits;
   } req_payload_type;

   // one result
   typedef struct packed {
      logic signed [VEL_WIDTH-1:0] vel_forward;
      logic signed [VEL_WIDTH-1:0] vel_strafe;
      logic signed [VEL_WIDTH-1:0] vel_turn;
      stop_cause_type              stop_cause;
      logic [SPEED_WIDTH-1:0]      linear_now;
      logic [SPEED_WIDTH-1:0]      turn_now;
   } rsp_payload_type;

   // mapper outputs towards the top level
   typedef struct packed {
      logic                        estop;
      logic signed [VEL_WIDTH-1:0] vel_forward;
      logic signed [VEL_WIDTH-1:0] vel_strafe;
      logic signed [VEL_WIDTH-1:0] vel_turn;
   } map_out_type;

endpackage

[rtl/gvm_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_req_if
// Request channel: gamepad sample or timer tick with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gvm_req_if;

   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [15:0] stick_x;
   logic signed [15:0] stick_y;
   logic signed [15:0] pad_vertical;
   logic signed [15:0] pad_horizontal;
   logic signed [15:0] trigger_left;
   logic signed [15:0] trigger_right;
   logic [5:0]         button_bits;

   modport source (
      output valid, mode, stick_x, stick_y, pad_vertical, pad_horizontal,
             trigger_left, trigger_right, button_bits,
      input  ready
   );

   modport sink (
      input  valid, mode, stick_x, stick_y, pad_vertical, pad_horizontal,
             trigger_left, trigger_right, button_bits,
      output ready
   );

endinterface

[rtl/gvm_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_rsp_if
// Result channel: velocity command and speed settings with valid/ready.
// ----------------------------------------------------------------------------
interface gvm_rsp_if;

   logic               valid;
   logic               ready;
   logic signed [15:0] vel_forward;
   logic signed [15:0] vel_strafe;
   logic signed [15:0] vel_turn;
   logic [1:0]         stop_cause;
   logic [14:0]        linear_now;
   logic [14:0]        turn_now;

   modport source (
      output valid, vel_forward, vel_strafe, vel_turn, stop_cause,
             linear_now, turn_now,
      input  ready
   );

   modport sink (
      input  valid, vel_forward, vel_strafe, vel_turn, stop_cause,
             linear_now, turn_now,
      output ready
   );

endinterface

[rtl/gamepad_to_velocity_mapper_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_to_velocity_mapper_core
// Maps gamepad samples and timer ticks to velocity commands, with button
// stepped speed settings, emergency stop and idle auto-stop.
//
//   channel   direction  handshake        carries
//   req_bus   in         valid/ready      sample or tick request
//   rsp_bus   out        valid/ready      velocity command and speed settings
//   csr       in/out     APB-style        six tuning registers
//
// One request per cycle while results are taken: it is captured in an input
// register and settled through one multiplier per stick axis and the two speed
// steppers into the result register.
// A tick that is still within the idle limit gives no result.
// Reset is synchronous; it empties both stages and restores the registers
// and speed settings. A stalled result holds the input register, which then
// holds req_bus.ready low until the result is taken.
// ----------------------------------------------------------------------------
module gamepad_to_velocity_mapper_core import gvm_pkg::*; #(
   parameter int IDLE_COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   gvm_req_if.sink                   req_bus,
   gvm_rsp_if.source                 rsp_bus,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int CMP_WIDTH = (IDLE_COUNT_WIDTH > IDLE_LIMIT_WIDTH)
                              ? IDLE_COUNT_WIDTH : IDLE_LIMIT_WIDTH;

   cfg_type                       cfg;
   speed_load_type                speed_load;
   map_out_type                   map_out;

   logic                          req_valid_ff, req_valid_in;
   req_payload_type               req_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_payload_type               rsp_data_ff, rsp_data_in;

   logic [SPEED_WIDTH-1:0]        linear_ff, linear_in;
   logic [SPEED_WIDTH-1:0]        turn_ff, turn_in;
   logic [HELD_WIDTH-1:0]         held_ff, held_in;
   logic [IDLE_COUNT_WIDTH-1:0]   idle_ff, idle_in;

   logic                          advance;
   logic                          is_tick;
   logic [HELD_WIDTH-1:0]         rise;
   logic [SPEED_WIDTH-1:0]        linear_step, turn_step;
   logic [IDLE_COUNT_WIDTH-1:0]   idle_inc;
   logic                          timeout;

   // register file
   gvm_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .speed_load (speed_load)
   );

   // handshake between the stages
   assign advance       = req_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~req_valid_ff | advance;
   assign is_tick       = (req_data_ff.mode == MODE_TICK);

   // button edges and speed steps
   assign rise = req_data_ff.button_bits[HELD_WIDTH-1:0] & ~held_ff;

   gvm_stepper u_step_linear (
      .speed       (linear_ff),
      .step_up     (rise[BTN_LIN_UP]),
      .step_down   (rise[BTN_LIN_DOWN]),
      .speed_step  (cfg.speed_step),
      .speed_limit (cfg.speed_limit),
      .speed_next  (linear_step)
   );

   gvm_stepper u_step_turn (
      .speed       (turn_ff),
      .step_up     (rise[BTN_TURN_UP]),
      .step_down   (rise[BTN_TURN_DOWN]),
      .speed_step  (cfg.speed_step),
      .speed_limit (cfg.speed_limit),
      .speed_next  (turn_step)
   );

   // velocity mapping with the stepped speeds
   gvm_mapper u_mapper (
      .item         (req_data_ff),
      .linear_speed (linear_step),
      .turn_speed   (turn_step),
      .dead_band    (cfg.dead_band),
      .map_out      (map_out)
   );

   // idle counter, saturating
   assign idle_inc = (idle_ff == {IDLE_COUNT_WIDTH{1'b1}}) ? idle_ff : idle_ff + 1'b1;
   assign timeout  = CMP_WIDTH'(idle_inc) > CMP_WIDTH'(cfg.idle_limit_ticks);

   // state update and result build
   always_comb begin
      linear_in    = linear_ff;
      turn_in      = turn_ff;
      held_in      = held_ff;
      idle_in      = idle_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_data_in            = '0;
         rsp_data_in.linear_now = linear_ff;
         rsp_data_in.turn_now   = turn_ff;
         if (is_tick) begin
            idle_in                = idle_inc;
            rsp_valid_in           = timeout;
            rsp_data_in.stop_cause = CAUSE_IDLE;
         end else begin
            idle_in      = '0;
            rsp_valid_in = 1'b1;
            if (map_out.estop) begin
               rsp_data_in.stop_cause = CAUSE_ESTOP;
            end else begin
               linear_in               = linear_step;
               turn_in                 = turn_step;
               held_in                 = req_data_ff.button_bits[HELD_WIDTH-1:0];
               rsp_data_in.stop_cause  = CAUSE_NORMAL;
               rsp_data_in.vel_forward = map_out.vel_forward;
               rsp_data_in.vel_strafe  = map_out.vel_strafe;
               rsp_data_in.vel_turn    = map_out.vel_turn;
               rsp_data_in.linear_now  = linear_step;
               rsp_data_in.turn_now    = turn_step;
            end
         end
      end
      // start register writes load the speed settings
      if (speed_load.load_linear) begin
         linear_in = speed_load.value;
      end
      if (speed_load.load_turn) begin
         turn_in = speed_load.value;
      end
   end

   // input stage valid
   always_comb begin
      req_valid_in = req_valid_ff & ~advance;
      if (req_bus.valid && req_bus.ready) begin
         req_valid_in = 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         linear_ff    <= RST_START_LINEAR;
         turn_ff      <= RST_START_TURN;
         held_ff      <= '0;
         idle_ff      <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         linear_ff    <= linear_in;
         turn_ff      <= turn_in;
         held_ff      <= held_in;
         idle_ff      <= idle_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         req_data_ff.mode           <= req_bus.mode;
         req_data_ff.stick_x        <= req_bus.stick_x;
         req_data_ff.stick_y        <= req_bus.stick_y;
         req_data_ff.pad_vertical   <= req_bus.pad_vertical;
         req_data_ff.pad_horizontal <= req_bus.pad_horizontal;
         req_data_ff.trigger_left   <= req_bus.trigger_left;
         req_data_ff.trigger_right  <= req_bus.trigger_right;
         req_data_ff.button_bits    <= req_bus.button_bits;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // result channel
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.vel_forward = rsp_data_ff.vel_forward;
   assign rsp_bus.vel_strafe  = rsp_data_ff.vel_strafe;
   assign rsp_bus.vel_turn    = rsp_data_ff.vel_turn;
   assign rsp_bus.stop_cause  = rsp_data_ff.stop_cause;
   assign rsp_bus.linear_now  = rsp_data_ff.linear_now;
   assign rsp_bus.turn_now    = rsp_data_ff.turn_now;

endmodule

[rtl/gvm_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_csr
// APB-style register file. Holds the tuning registers and signals a load of
// the speed settings whenever a start speed register is written.
// ----------------------------------------------------------------------------
module gvm_csr import gvm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg,
   output speed_load_type            speed_load
);

   cfg_type                      cfg_ff, cfg_in;
   logic [SPEED_WIDTH-1:0]       start_linear_ff, start_linear_in;
   logic [SPEED_WIDTH-1:0]       start_turn_ff, start_turn_in;
   logic                         wr_en;
   logic [CSR_INDEX_WIDTH-1:0]   wr_index;
   logic [SPEED_WIDTH-1:0]       wr_speed;

   assign pready   = 1'b1;
   assign wr_en    = psel & penable & pwrite & pready;
   assign wr_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_speed = pwdata[SPEED_WIDTH-1:0];

   // register write decode
   always_comb begin
      cfg_in          = cfg_ff;
      start_linear_in = start_linear_ff;
      start_turn_in   = start_turn_ff;
      speed_load      = '0;
      speed_load.value = wr_speed;
      if (wr_en) begin
         unique case (wr_index)
            REG_DEAD_BAND:    cfg_in.dead_band   = wr_speed;
            REG_SPEED_STEP:   cfg_in.speed_step  = wr_speed;
            REG_SPEED_LIMIT:  cfg_in.speed_limit = wr_speed;
            REG_IDLE_LIMIT:   cfg_in.idle_limit_ticks = pwdata[IDLE_LIMIT_WIDTH-1:0];
            REG_START_LINEAR: begin
               start_linear_in        = wr_speed;
               speed_load.load_linear = 1'b1;
            end
            REG_START_TURN: begin
               start_turn_in        = wr_speed;
               speed_load.load_turn = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // register state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_band        <= RST_DEAD_BAND;
         cfg_ff.speed_step       <= RST_SPEED_STEP;
         cfg_ff.speed_limit      <= RST_SPEED_LIMIT;
         cfg_ff.idle_limit_ticks <= RST_IDLE_LIMIT;
         start_linear_ff         <= RST_START_LINEAR;
         start_turn_ff           <= RST_START_TURN;
      end else begin
         cfg_ff          <= cfg_in;
         start_linear_ff <= start_linear_in;
         start_turn_ff   <= start_turn_in;
      end
   end

   // read back
   always_comb begin
      unique case (wr_index)
         REG_DEAD_BAND:    prdata = CSR_DATA_WIDTH'(cfg_ff.dead_band);
         REG_SPEED_STEP:   prdata = CSR_DATA_WIDTH'(cfg_ff.speed_step);
         REG_SPEED_LIMIT:  prdata = CSR_DATA_WIDTH'(cfg_ff.speed_limit);
         REG_IDLE_LIMIT:   prdata = CSR_DATA_WIDTH'(cfg_ff.idle_limit_ticks);
         REG_START_LINEAR: prdata = CSR_DATA_WIDTH'(start_linear_ff);
         REG_START_TURN:   prdata = CSR_DATA_WIDTH'(start_turn_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/gvm_stepper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_stepper
// Speed setting adjust: an up press adds the step and clamps to the limit,
// then a down press subtracts the step and clamps at zero.
// ----------------------------------------------------------------------------
module gvm_stepper import gvm_pkg::*; (
   input  logic [SPEED_WIDTH-1:0] speed,
   input  logic                   step_up,
   input  logic                   step_down,
   input  logic [SPEED_WIDTH-1:0] speed_step,
   input  logic [SPEED_WIDTH-1:0] speed_limit,
   output logic [SPEED_WIDTH-1:0] speed_next
);

   logic [SPEED_WIDTH:0]   up_sum;
   logic [SPEED_WIDTH-1:0] after_up;

   // clamped increase
   always_comb begin
      up_sum = {1'b0, speed} + {1'b0, speed_step};
      if (!step_up) begin
         after_up = speed;
      end else if (up_sum < {1'b0, speed_limit}) begin
         after_up = up_sum[SPEED_WIDTH-1:0];
      end else begin
         after_up = speed_limit;
      end
   end

   // clamped decrease
   always_comb begin
      if (!step_down) begin
         speed_next = after_up;
      end else if (after_up > speed_step) begin
         speed_next = after_up - speed_step;
      end else begin
         speed_next = '0;
      end
   end

endmodule

[rtl/gvm_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_mapper
// Velocity mapping of one gamepad sample: emergency stop detect, d-pad and
// shoulder overrides, stick deadzone and scaling by the linear speed.
// ----------------------------------------------------------------------------
module gvm_mapper import gvm_pkg::*; (
   input  req_payload_type        item,
   input  logic [SPEED_WIDTH-1:0] linear_speed,
   input  logic [SPEED_WIDTH-1:0] turn_speed,
   input  logic [SPEED_WIDTH-1:0] dead_band,
   output map_out_type            map_out
);

   logic signed [VEL_WIDTH-1:0] lin_pos, lin_neg, turn_pos, turn_neg;
   logic                        pad_fwd_pos, pad_fwd_neg, pad_str_pos, pad_str_neg;
   logic                        pad_active;
   logic [AXIS_WIDTH:0]         mag_y, mag_x;
   logic signed [31:0]          prod_y, prod_x, round_y, round_x;

   assign lin_pos  = VEL_WIDTH'(signed'({1'b0, linear_speed}));
   assign lin_neg  = -lin_pos;
   assign turn_pos = VEL_WIDTH'(signed'({1'b0, turn_speed}));
   assign turn_neg = -turn_pos;

   // d-pad axis activity
   assign pad_fwd_pos = item.pad_vertical   > AXIS_HALF_POS;
   assign pad_fwd_neg = item.pad_vertical   < AXIS_HALF_NEG;
   assign pad_str_pos = item.pad_horizontal > AXIS_HALF_POS;
   assign pad_str_neg = item.pad_horizontal < AXIS_HALF_NEG;
   assign pad_active  = pad_fwd_pos | pad_fwd_neg | pad_str_pos | pad_str_neg
                        | item.button_bits[BTN_TURN_LEFT]
                        | item.button_bits[BTN_TURN_RIGHT];

   // stick magnitudes, full negative has magnitude 32768
   assign mag_y = item.stick_y[AXIS_WIDTH-1] ? (AXIS_WIDTH+1)'(-{item.stick_y[AXIS_WIDTH-1], item.stick_y})
                                             : {1'b0, item.stick_y};
   assign mag_x = item.stick_x[AXIS_WIDTH-1] ? (AXIS_WIDTH+1)'(-{item.stick_x[AXIS_WIDTH-1], item.stick_x})
                                             : {1'b0, item.stick_x};

   // Q4.12 x Q1.15 with round half up, back to Q4.12
   assign prod_y  = signed'({1'b0, linear_speed}) * item.stick_y;
   assign prod_x  = signed'({1'b0, linear_speed}) * item.stick_x;
   assign round_y = prod_y + SCALE_ROUND;
   assign round_x = prod_x + SCALE_ROUND;

   // command selection
   always_comb begin
      map_out       = '0;
      map_out.estop = (item.trigger_left < AXIS_HALF_NEG)
                      && (item.trigger_right < AXIS_HALF_NEG);
      if (!map_out.estop) begin
         if (pad_fwd_pos) begin
            map_out.vel_forward = lin_pos;
         end else if (pad_fwd_neg) begin
            map_out.vel_forward = lin_neg;
         end
         if (pad_str_pos) begin
            map_out.vel_strafe = lin_pos;
         end else if (pad_str_neg) begin
            map_out.vel_strafe = lin_neg;
         end
         // turn right wins over turn left
         if (item.button_bits[BTN_TURN_RIGHT]) begin
            map_out.vel_turn = turn_pos;
         end else if (item.button_bits[BTN_TURN_LEFT]) begin
            map_out.vel_turn = turn_neg;
         end
         if (!pad_active) begin
            if (mag_y > {2'b00, dead_band}) begin
               map_out.vel_forward = round_y[30:15];
            end
            if (mag_x > {2'b00, dead_band}) begin
               map_out.vel_strafe = round_x[30:15];
            end
         end
      end
   end

endmodule
